### rtl/syip_pkg.sv
// Shared types and constants of the shunting-yard infix to postfix converter.
package syip_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  localparam int KIND_W  = 3;
  localparam int CODE_W  = 3;
  localparam int VALUE_W = 64;
  localparam int ENTRY_W = KIND_W + CODE_W;

  // Binary codes with this bit set belong to the * and / group.
  localparam int HI_PRIO_BIT = 1;

  localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VARIABLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FUNCTION = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNARY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BINARY   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd7;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;      // capture the input token code
    logic push_in;    // push the input token
    logic push_lat;   // push the captured binary operator
    logic pop;        // drop the top entry
    logic hold_top;   // load the hold slot from the top entry
    logic hold_end;   // load the hold slot with an end token
    logic out_in;     // load the output register from the input token
    logic out_hold;   // load the output register from the hold slot
    logic out_last;   // last_of_run for out_hold
    logic clr_flag;   // clear the sticky overflow flag
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;
    logic top_open;
    logic top_func;
    logic bin_pop;    // top entry must pop before the captured binary op
  } status_t;

endpackage

### rtl/syip_if.sv
// Handshake channel interfaces for infix tokens and postfix results.
interface syip_tok_if;
  logic                          valid;
  logic                          ready;
  logic [syip_pkg::KIND_W-1:0]   token_kind;
  logic [syip_pkg::CODE_W-1:0]   token_code;
  logic [syip_pkg::VALUE_W-1:0]  token_value;

  modport source (output valid, output token_kind, output token_code, output token_value,
                  input ready);
  modport sink   (input valid, input token_kind, input token_code, input token_value,
                  output ready);
endinterface

interface syip_res_if;
  logic                          valid;
  logic                          ready;
  logic [syip_pkg::KIND_W-1:0]   out_kind;
  logic [syip_pkg::CODE_W-1:0]   out_code;
  logic [syip_pkg::VALUE_W-1:0]  out_value;
  logic                          last_of_run;
  logic                          stack_overflowed;

  modport source (output valid, output out_kind, output out_code, output out_value,
                  output last_of_run, output stack_overflowed, input ready);
  modport sink   (input valid, input out_kind, input out_code, input out_value,
                  input last_of_run, input stack_overflowed, output ready);
endinterface

### rtl/syip_dp.sv
// Datapath: operator stack memory, overflow flag, hold slot and output register.
module syip_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [syip_pkg::KIND_W-1:0]  in_kind,
  input  logic [syip_pkg::CODE_W-1:0]  in_code,
  input  logic [syip_pkg::VALUE_W-1:0] in_value,
  input  syip_pkg::cmd_t               cmd,
  output syip_pkg::status_t            st,
  output logic [syip_pkg::KIND_W-1:0]  out_kind,
  output logic [syip_pkg::CODE_W-1:0]  out_code,
  output logic [syip_pkg::VALUE_W-1:0] out_value,
  output logic                         out_last,
  output logic                         out_flag
);

  logic [syip_pkg::ENTRY_W-1:0] mem [syip_pkg::STACK_DEPTH];

  logic [syip_pkg::CNT_W-1:0]   count_r, count_nxt, cnt_m1;
  logic                         flag_r;
  logic [syip_pkg::CODE_W-1:0]  op_code_r;
  logic [syip_pkg::ENTRY_W-1:0] top_r;
  logic [syip_pkg::IDX_W-1:0]   rd_addr, waddr;
  logic [syip_pkg::ENTRY_W-1:0] wdata;
  logic                         full, push_req, we;
  logic [syip_pkg::KIND_W-1:0]  top_kind;
  logic [syip_pkg::CODE_W-1:0]  top_code;

  logic [syip_pkg::KIND_W-1:0]  hold_kind_r;
  logic [syip_pkg::CODE_W-1:0]  hold_code_r;
  logic                         hold_flag_r;

  logic [syip_pkg::KIND_W-1:0]  out_kind_r;
  logic [syip_pkg::CODE_W-1:0]  out_code_r;
  logic [syip_pkg::VALUE_W-1:0] out_value_r;
  logic                         out_last_r;
  logic                         out_flag_r;

  assign top_kind = top_r[syip_pkg::ENTRY_W-1:syip_pkg::CODE_W];
  assign top_code = top_r[syip_pkg::CODE_W-1:0];

  assign full     = (count_r == syip_pkg::CNT_W'(syip_pkg::STACK_DEPTH));
  assign push_req = cmd.push_in | cmd.push_lat;
  assign we       = push_req & ~full;
  assign waddr    = count_r[syip_pkg::IDX_W-1:0];
  assign wdata    = cmd.push_lat ? {syip_pkg::KIND_BINARY, op_code_r} : {in_kind, in_code};

  always_comb begin
    count_nxt = count_r;
    if (we) begin
      count_nxt = count_r + syip_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - syip_pkg::CNT_W'(1);
    end
  end

  // Keep the top entry of the next cycle registered at the read port.
  assign cnt_m1  = count_nxt - syip_pkg::CNT_W'(1);
  assign rd_addr = cnt_m1[syip_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == rd_addr)) begin
      top_r <= wdata;
    end else begin
      top_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push_req && full) begin
        flag_r <= 1'b1;
      end else if (cmd.clr_flag) begin
        flag_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_code_r <= in_code;
    end
    if (cmd.hold_top) begin
      hold_kind_r <= top_kind;
      hold_code_r <= top_code;
      hold_flag_r <= flag_r;
    end else if (cmd.hold_end) begin
      hold_kind_r <= syip_pkg::KIND_END;
      hold_code_r <= syip_pkg::CODE_NONE;
      hold_flag_r <= flag_r;
    end
    if (cmd.out_in) begin
      out_kind_r  <= in_kind;
      out_code_r  <= syip_pkg::CODE_NONE;
      out_value_r <= (in_kind == syip_pkg::KIND_NUMBER) ? in_value : '0;
      out_last_r  <= 1'b1;
      out_flag_r  <= flag_r;
    end else if (cmd.out_hold) begin
      out_kind_r  <= hold_kind_r;
      out_code_r  <= hold_code_r;
      out_value_r <= '0;
      out_last_r  <= cmd.out_last;
      out_flag_r  <= hold_flag_r;
    end
  end

  always_comb begin
    st.empty    = (count_r == '0);
    st.top_open = ~st.empty & (top_kind == syip_pkg::KIND_OPEN);
    st.top_func = ~st.empty & (top_kind == syip_pkg::KIND_FUNCTION);
    st.bin_pop  = ~st.empty
                & ((top_kind == syip_pkg::KIND_BINARY) | (top_kind == syip_pkg::KIND_UNARY))
                & (~op_code_r[syip_pkg::HI_PRIO_BIT] | (top_kind == syip_pkg::KIND_UNARY)
                   | top_code[syip_pkg::HI_PRIO_BIT]);
  end

  assign out_kind  = out_kind_r;
  assign out_code  = out_code_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_flag  = out_flag_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= syip_pkg::CNT_W'(syip_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty stack");
  a_full_push_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (push_req && full) |=> flag_r && (count_r == $past(count_r)))
    else $error("dropped push did not set flag");
`endif

endmodule

### rtl/syip_ctrl.sv
// Controller: sequences pops, hold slot and output register per input token.
module syip_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [syip_pkg::KIND_W-1:0] in_kind,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  input  syip_pkg::status_t           st,
  output syip_pkg::cmd_t              cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BIN   = 6'b000010,
    S_CLOSE = 6'b000100,
    S_FUNC  = 6'b001000,
    S_END   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   hold_v_r, hold_v_nxt;
  logic   out_valid_r;
  logic   oslot, in_fire, out_load;

  assign oslot    = ~out_valid_r | out_ready;
  assign in_ready = (state_r == S_IDLE) & oslot;
  assign in_fire  = in_valid & in_ready;
  assign out_load = cmd.out_in | cmd.out_hold;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    hold_v_nxt = hold_v_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          case (in_kind)
            syip_pkg::KIND_NUMBER,
            syip_pkg::KIND_VARIABLE: cmd.out_in = 1'b1;
            syip_pkg::KIND_FUNCTION,
            syip_pkg::KIND_UNARY,
            syip_pkg::KIND_OPEN:     cmd.push_in = 1'b1;
            syip_pkg::KIND_BINARY:   state_nxt = S_BIN;
            syip_pkg::KIND_CLOSE:    state_nxt = S_CLOSE;
            default:                 state_nxt = S_END;
          endcase
        end
      end
      S_BIN: begin
        if (oslot) begin
          if (st.bin_pop) begin
            cmd.pop      = 1'b1;
            cmd.hold_top = 1'b1;
          end else begin
            cmd.push_lat = 1'b1;
            state_nxt    = S_FIN;
          end
        end
      end
      S_CLOSE: begin
        if (oslot) begin
          if (st.empty) begin
            state_nxt = S_FIN;
          end else if (st.top_open) begin
            // Discard the matching open paren.
            cmd.pop   = 1'b1;
            state_nxt = S_FUNC;
          end else begin
            cmd.pop      = 1'b1;
            cmd.hold_top = 1'b1;
          end
        end
      end
      S_FUNC: begin
        if (oslot) begin
          if (st.top_func) begin
            cmd.pop      = 1'b1;
            cmd.hold_top = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_END: begin
        if (oslot) begin
          if (!st.empty) begin
            cmd.pop      = 1'b1;
            cmd.hold_top = 1'b1;
          end else begin
            cmd.hold_end = 1'b1;
            cmd.clr_flag = 1'b1;
            state_nxt    = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (oslot) begin
          if (hold_v_r) begin
            cmd.out_hold = 1'b1;
            cmd.out_last = 1'b1;
          end
          hold_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt  = S_IDLE;
        hold_v_nxt = 1'b0;
      end
    endcase

    // A new token for the hold slot pushes the previous one out, not last.
    if (cmd.hold_top || cmd.hold_end) begin
      if (hold_v_r) begin
        cmd.out_hold = 1'b1;
        cmd.out_last = 1'b0;
      end
      hold_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_v_r)
    else $error("hold slot occupied while idle");
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
  a_push_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == syip_pkg::KIND_OPEN)) |=> (state_r == S_IDLE))
    else $error("push token left idle");
  a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && oslot) |=> (state_r == S_IDLE) && !hold_v_r)
    else $error("finish did not return to idle");
`endif

endmodule

### rtl/shunting_yard_infix_to_postfix_top.sv
// Streaming shunting-yard converter turning infix tokens into postfix tokens.
// Numbers and the variable become one result with last_of_run set; functions,
// unary ops and open parens are pushed with no result. A binary op or the end marker
// steps through accept, one pop per popped stack entry, the push or the end token and
// finish; a close paren steps through accept, one pop per popped entry, the discarded
// open paren included, a possible pop of a function, and finish. Each step waits
// while the output register is full and not being drained. The rate is set by the
// single read port of the operator stack (one pop per cycle while the output register
// can take a result) and a one-token hold slot that marks the last result of a run.
// A new token is taken only when the converter is idle and its output register is free
// or being drained. The stack holds STACK_DEPTH entries; a push onto a full stack is
// dropped and raises stack_overflowed until the next end marker's result has gone out.
module shunting_yard_infix_to_postfix_top (
  input  logic         clk,
  input  logic         rst_n,
  syip_tok_if.sink     in_ch,
  syip_res_if.source   out_ch
);

  syip_pkg::cmd_t    cmd;
  syip_pkg::status_t st;

  syip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.token_kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  syip_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_kind   (in_ch.token_kind),
    .in_code   (in_ch.token_code),
    .in_value  (in_ch.token_value),
    .cmd       (cmd),
    .st        (st),
    .out_kind  (out_ch.out_kind),
    .out_code  (out_ch.out_code),
    .out_value (out_ch.out_value),
    .out_last  (out_ch.last_of_run),
    .out_flag  (out_ch.stack_overflowed)
  );

endmodule

### tb/shunting_yard_infix_to_postfix_checker.sv
// Checker for the infix to postfix converter: predicts postfix tokens and compares results.
`timescale 1ns / 1ps

module shunting_yard_infix_to_postfix_checker
  import syip_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CODE_W-1:0]  in_code,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [KIND_W-1:0]  out_kind,
  input  logic [CODE_W-1:0]  out_code,
  input  logic [VALUE_W-1:0] out_value,
  input  logic               out_last,
  input  logic               out_ovf,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } postfix_t;

  logic [ENTRY_W-1:0] op_stk [STACK_DEPTH];
  int                 op_cnt;
  logic               ovf_sticky;
  postfix_t           postfix_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    op_cnt      = 0;
    ovf_sticky  = 1'b0;
  end

  function automatic logic [KIND_W-1:0] top_kind();
    return op_stk[IDX_W'(op_cnt-1)][ENTRY_W-1:CODE_W];
  endfunction

  function automatic logic [CODE_W-1:0] top_code();
    return op_stk[IDX_W'(op_cnt-1)][CODE_W-1:0];
  endfunction

  task automatic emit_tok(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                          input logic [VALUE_W-1:0] value);
    postfix_t r;
    r.kind  = kind;
    r.code  = code;
    r.value = value;
    r.last  = 1'b0;
    r.ovf   = ovf_sticky;
    postfix_q.push_back(r);
  endtask

  task automatic push_op(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code);
    if (op_cnt >= STACK_DEPTH) begin
      // drop the push, remember it until the next end marker
      ovf_sticky = 1'b1;
    end else begin
      op_stk[IDX_W'(op_cnt)] = {kind, code};
      op_cnt++;
    end
  endtask

  task automatic pop_op();
    emit_tok(top_kind(), top_code(), '0);
    op_cnt--;
  endtask

  task automatic convert_token(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                               input logic [VALUE_W-1:0] value);
    int                start;
    bit                low_new;
    bit                stop;
    logic [KIND_W-1:0] tk;
    logic [CODE_W-1:0] tc;
    postfix_t          r;
    start = postfix_q.size();
    stop  = 1'b0;
    case (kind)
      KIND_NUMBER:   emit_tok(KIND_NUMBER, CODE_NONE, value);
      KIND_VARIABLE: emit_tok(KIND_VARIABLE, CODE_NONE, '0);
      KIND_FUNCTION, KIND_UNARY, KIND_OPEN: push_op(kind, code);
      KIND_BINARY: begin
        low_new = !code[HI_PRIO_BIT];
        while (op_cnt > 0 && !stop) begin
          tk = top_kind();
          tc = top_code();
          if ((tk == KIND_BINARY || tk == KIND_UNARY) &&
              (low_new || tk == KIND_UNARY || tc[HI_PRIO_BIT]))
            pop_op();
          else
            stop = 1'b1;
        end
        push_op(kind, code);
      end
      KIND_CLOSE: begin
        while (op_cnt > 0 && !stop) begin
          if (top_kind() == KIND_OPEN) begin
            op_cnt--;
            stop = 1'b1;
          end else begin
            pop_op();
          end
        end
        if (op_cnt > 0 && top_kind() == KIND_FUNCTION)
          pop_op();
      end
      default: begin
        while (op_cnt > 0)
          pop_op();
        emit_tok(KIND_END, CODE_NONE, '0);
        ovf_sticky = 1'b0;
      end
    endcase
    if (postfix_q.size() > start) begin
      r = postfix_q.pop_back();
      r.last = 1'b1;
      postfix_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                             input logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    postfix_t exp_r;
    if (!rst_n) begin
      op_cnt     = 0;
      ovf_sticky = 1'b0;
      postfix_q.delete();
    end else begin
      if (in_valid && in_ready)
        convert_token(in_kind, in_code, in_value);
      if (out_valid && out_ready) begin
        if (postfix_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %h code %h value %h",
                   $realtime, out_kind, out_code, out_value);
          mismatches++;
        end else begin
          exp_r = postfix_q.pop_front();
          check_field("out_kind", VALUE_W'(exp_r.kind), VALUE_W'(out_kind));
          check_field("out_code", VALUE_W'(exp_r.code), VALUE_W'(out_code));
          check_field("out_value", exp_r.value, out_value);
          check_field("last_of_run", VALUE_W'(exp_r.last), VALUE_W'(out_last));
          check_field("stack_overflowed", VALUE_W'(exp_r.ovf), VALUE_W'(out_ovf));
        end
      end
    end
    outstanding = postfix_q.size();
  end

endmodule

### tb/shunting_yard_infix_to_postfix_top_test.sv
// Top of the infix to postfix converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module shunting_yard_infix_to_postfix_top_test;
  import syip_pkg::*;

  localparam logic [CODE_W-1:0] OP_ADD      = 3'd0;
  localparam logic [CODE_W-1:0] OP_SUB      = 3'd1;
  localparam logic [CODE_W-1:0] OP_MUL      = 3'd2;
  localparam logic [CODE_W-1:0] OP_DIV      = 3'd3;
  localparam logic [CODE_W-1:0] OP_LO_ALIAS = 3'd4;
  localparam logic [CODE_W-1:0] OP_HI_ALIAS = 3'd6;
  localparam logic [CODE_W-1:0] UN_MINUS    = 3'd0;
  localparam logic [CODE_W-1:0] UN_PLUS     = 3'd1;
  localparam logic [CODE_W-1:0] FN_SIN      = 3'd0;
  localparam logic [CODE_W-1:0] FN_LN       = 3'd5;
  localparam logic [CODE_W-1:0] CODE_ONES   = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
  } infix_tok_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  infix_tok_t infix_q [$];
  int         mismatches;
  int         outstanding;
  int         accepted = 0;
  bit         quiet = 1'b0;
  bit         long_hold_done = 1'b0;

  syip_tok_if in_ch ();
  syip_res_if out_ch ();

  shunting_yard_infix_to_postfix_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  shunting_yard_infix_to_postfix_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_kind     (in_ch.token_kind),
    .in_code     (in_ch.token_code),
    .in_value    (in_ch.token_value),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.out_kind),
    .out_code    (out_ch.out_code),
    .out_value   (out_ch.out_value),
    .out_last    (out_ch.last_of_run),
    .out_ovf     (out_ch.stack_overflowed),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  function automatic logic [VALUE_W-1:0] rnd_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CODE_W-1:0] rnd_code();
    return CODE_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [KIND_W-1:0] rnd_kind();
    return KIND_W'($urandom_range(0, 7));
  endfunction

  task automatic put_tok(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                         input logic [VALUE_W-1:0] value);
    infix_tok_t t;
    t.kind  = kind;
    t.code  = code;
    t.value = value;
    infix_q.push_back(t);
  endtask

  // Stimulus: directed tokens, then random expressions, then the verdict.
  initial begin
    int depth;
    int n;
    int max_len;
    int r;
    int k;
    int len;
    int deep_left;
    int quiet_from;
    bit need_opnd;
    bit done;

    in_ch.valid       <= 1'b0;
    in_ch.token_kind  <= KIND_NUMBER;
    in_ch.token_code  <= CODE_NONE;
    in_ch.token_value <= '0;

    // directed: all-ones and zero payloads, every kind and operator group
    put_tok(KIND_NUMBER, CODE_ONES, {VALUE_W{1'b1}});
    put_tok(KIND_BINARY, OP_ADD, rnd_value());
    put_tok(KIND_UNARY, UN_MINUS, rnd_value());
    put_tok(KIND_NUMBER, CODE_NONE, '0);
    put_tok(KIND_BINARY, OP_MUL, rnd_value());
    put_tok(KIND_FUNCTION, FN_LN, rnd_value());
    put_tok(KIND_OPEN, CODE_NONE, rnd_value());
    put_tok(KIND_VARIABLE, CODE_ONES, {VALUE_W{1'b1}});
    put_tok(KIND_BINARY, OP_DIV, rnd_value());
    put_tok(KIND_VARIABLE, CODE_NONE, '0);
    put_tok(KIND_BINARY, OP_SUB, rnd_value());
    put_tok(KIND_NUMBER, CODE_NONE, rnd_value());
    put_tok(KIND_CLOSE, CODE_NONE, rnd_value());
    put_tok(KIND_BINARY, OP_HI_ALIAS, rnd_value());
    put_tok(KIND_OPEN, CODE_ONES, rnd_value());
    put_tok(KIND_UNARY, UN_PLUS, rnd_value());
    put_tok(KIND_VARIABLE, CODE_NONE, rnd_value());
    put_tok(KIND_END, CODE_NONE, '0);
    // unmatched close paren, on an empty and on a non-empty stack
    put_tok(KIND_CLOSE, CODE_ONES, {VALUE_W{1'b1}});
    put_tok(KIND_VARIABLE, CODE_NONE, rnd_value());
    put_tok(KIND_BINARY, OP_LO_ALIAS, rnd_value());
    put_tok(KIND_FUNCTION, FN_SIN, rnd_value());
    put_tok(KIND_CLOSE, CODE_NONE, rnd_value());
    // leftover open paren flushed by the end marker
    put_tok(KIND_OPEN, CODE_NONE, rnd_value());
    put_tok(KIND_END, CODE_ONES, {VALUE_W{1'b1}});

    deep_left = 3;
    while (infix_q.size() < 265) begin
      if (deep_left > 0 && $urandom_range(0, 15) == 0) begin
        // nest past the stack depth so pushes get dropped
        deep_left--;
        len = $urandom_range(30, 40);
        for (k = 0; k < len; k++) begin
          r = $urandom_range(0, 9);
          if (r < 4)
            put_tok(KIND_OPEN, rnd_code(), rnd_value());
          else if (r < 7)
            put_tok(KIND_UNARY, rnd_code(), rnd_value());
          else if (r < 9)
            put_tok(KIND_FUNCTION, rnd_code(), rnd_value());
          else
            put_tok(KIND_VARIABLE, rnd_code(), rnd_value());
        end
        if ($urandom_range(0, 1) == 1)
          put_tok(KIND_BINARY, rnd_code(), rnd_value());
        put_tok(KIND_END, rnd_code(), rnd_value());
      end else begin
        // well-formed expression with a little noise mixed in
        depth     = 0;
        n         = 0;
        need_opnd = 1'b1;
        done      = 1'b0;
        max_len   = $urandom_range(1, 12);
        while (!done) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            put_tok(rnd_kind(), rnd_code(), rnd_value());
          end else if (need_opnd) begin
            if (n >= max_len || r < 8) begin
              put_tok(KIND_NUMBER, rnd_code(), rnd_value());
              need_opnd = 1'b0;
            end else if (r < 11) begin
              put_tok(KIND_VARIABLE, rnd_code(), rnd_value());
              need_opnd = 1'b0;
            end else if (r < 13) begin
              put_tok(KIND_UNARY, rnd_code(), rnd_value());
            end else if (r < 16) begin
              put_tok(KIND_FUNCTION, rnd_code(), rnd_value());
              put_tok(KIND_OPEN, rnd_code(), rnd_value());
              depth++;
            end else begin
              put_tok(KIND_OPEN, rnd_code(), rnd_value());
              depth++;
            end
          end else if (depth > 0 && (r < 6 || n >= max_len)) begin
            if (n >= max_len && r < 4) begin
              done = 1'b1;  // leave open parens for the end marker
            end else begin
              put_tok(KIND_CLOSE, rnd_code(), rnd_value());
              depth--;
            end
          end else if (n >= max_len) begin
            done = 1'b1;
          end else begin
            put_tok(KIND_BINARY, rnd_code(), rnd_value());
            need_opnd = 1'b1;
          end
          n++;
        end
        put_tok(KIND_END, rnd_code(), rnd_value());
      end
    end

    quiet_from = infix_q.size() * 85 / 100;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < infix_q.size(); k++) begin
      quiet = (k >= quiet_from);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.token_kind  <= infix_q[k].kind;
      in_ch.token_code  <= infix_q[k].code;
      in_ch.token_value <= infix_q[k].value;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      accepted++;
    end
    in_ch.valid <= 1'b0;

    // let the checker book the last transfer before polling its count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("shunting_yard_infix_to_postfix_top verification clean");
    else
      $display("shunting_yard_infix_to_postfix_top verification failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up, none at the end.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_hold_done && accepted >= 60) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          out_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("shunting_yard_infix_to_postfix_top verification failed");
    $finish;
  end

endmodule

### files.f
rtl/syip_pkg.sv
rtl/syip_if.sv
rtl/syip_dp.sv
rtl/syip_ctrl.sv
rtl/shunting_yard_infix_to_postfix_top.sv
tb/shunting_yard_infix_to_postfix_checker.sv
tb/shunting_yard_infix_to_postfix_top_test.sv
